// File: src/pba_pkg.sv
// Shared widths, operation codes and status codes of the page bitmap allocator.
package pba_pkg;

    // Fixed field widths of the request and response channels.
    localparam int OP_W    = 2;
    localparam int ADDR_W  = 40;
    localparam int CNT_W   = 20;
    localparam int ALIGN_W = 6;
    localparam int STAT_W  = 3;
    localparam int USED_W  = 17;
    localparam int CFG_W   = 17;

    // Operation codes carried in the request.
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_CLAIM   = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    // Status codes returned in the response.
    typedef enum logic [STAT_W-1:0] {
        ST_OK           = 3'd0,
        ST_INVALID      = 3'd1,
        ST_NO_SPACE     = 3'd2,
        ST_DOUBLE_FREE  = 3'd3,
        ST_OUT_OF_RANGE = 3'd4
    } status_t;

endpackage

// File: src/pba_if.sv
// Request and response channel interfaces of the page bitmap allocator.
interface pba_req_if
    import pba_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      opcode;
    logic [ADDR_W-1:0]    start_address;
    logic [ADDR_W-1:0]    end_address;
    logic [CNT_W-1:0]     page_count;
    logic [ALIGN_W-1:0]   align_log2;
    logic                 strict;

    modport source
    (
        output valid, opcode, start_address, end_address, page_count, align_log2, strict,
        input  ready
    );
    modport sink
    (
        input  valid, opcode, start_address, end_address, page_count, align_log2, strict,
        output ready
    );
endinterface

interface pba_rsp_if
    import pba_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [STAT_W-1:0]    status;
    logic [ADDR_W-1:0]    result_address;
    logic [USED_W-1:0]    used_pages;

    modport source
    (
        output valid, status, result_address, used_pages,
        input  ready
    );
    modport sink
    (
        input  valid, status, result_address, used_pages,
        output ready
    );
endinterface

// File: src/page_bitmap_allocator_core.sv
// Page bitmap allocator: used-page map in one memory, scanned word by word by a sequencer.
// After reset or a managed_pages write the map is filled with ones, one word per cycle
// (NUM_PAGES/MAP_WORD_BITS words, 1024 by default); no request is taken meanwhile.
// Claim and release read and rewrite each map word in the range; a strict release first
// reads each word of the range for its free-page check. Allocate reads words in turn,
// trying each free run in a word, then rewrites each word it marks. One request at a time.
// Reset is asynchronous, active low; it clears the control state and starts the fill.
module page_bitmap_allocator_core
    import pba_pkg::*;
#(
    parameter int NUM_PAGES     = 65536,
    parameter int PAGE_SHIFT    = 12,
    parameter int MAP_WORD_BITS = 64,
    parameter int ADDRESS_BITS  = 40
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    pba_req_if.sink          req,
    pba_rsp_if.source        rsp
);

    // Derived sizes.
    localparam int WB     = MAP_WORD_BITS;
    localparam int WBL    = $clog2(WB);
    localparam int WORDS  = (NUM_PAGES + WB - 1) / WB;
    localparam int WI_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW     = WI_W + WBL;
    localparam int CW     = $clog2(NUM_PAGES + 1);
    localparam int PB     = ((CW > PW) ? CW : PW) + 1;
    localparam int PGW    = ADDR_W - PAGE_SHIFT + 1;
    localparam int XW     = (PGW > PB) ? PGW : PB;
    localparam int KW     = (CW > CNT_W) ? CW : CNT_W;
    localparam int UW     = (CW > CFG_W) ? CW : CFG_W;
    localparam int AB     = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
    localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - AB);
    localparam logic [WI_W-1:0]   WI_LAST   = WI_W'(WORDS - 1);
    localparam logic [WB-1:0]     ONES      = {WB{1'b1}};

    typedef enum logic [9:0] {
        S_FILL  = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_DEC   = 10'b0000000100,
        S_ARD   = 10'b0000001000,
        S_ASCAN = 10'b0000010000,
        S_CRD   = 10'b0000100000,
        S_CCHK  = 10'b0001000000,
        S_MRD   = 10'b0010000000,
        S_MWR   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    // Index of the lowest set bit, or WB when none is set.
    function automatic logic [WBL:0] lsb_idx(input logic [WB-1:0] v);
        logic [WBL:0] r;
        r = (WBL+1)'(WB);
        for (int i = WB - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = (WBL+1)'(i);
            end
        end
        return r;
    endfunction

    // Number of set bits in one map word.
    function automatic logic [WBL:0] popcnt(input logic [WB-1:0] v);
        logic [WBL:0] c;
        c = '0;
        for (int i = 0; i < WB; i++)
        begin
            c = c + (WBL+1)'(v[i]);
        end
        return c;
    endfunction

    state_t              state_reg,  state_next;
    logic [WI_W-1:0]     w_reg,      w_next;
    logic [WI_W-1:0]     wlast_reg,  wlast_next;
    logic [WBL:0]        s_reg,      s_next;
    logic                pend_reg,   pend_next;
    logic [CNT_W-1:0]    need_reg,   need_next;
    logic [PB-1:0]       cand_reg,   cand_next;
    logic [PB-1:0]       rs_reg,     rs_next;
    logic [PB-1:0]       re_reg,     re_next;
    logic                setm_reg,   setm_next;
    logic                strict_reg, strict_next;
    logic [OP_W-1:0]     op_reg,     op_next;
    logic [ADDR_W-1:0]   start_reg,  start_next;
    logic [ADDR_W-1:0]   end_reg,    end_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [ALIGN_W-1:0]  align_reg,  align_next;
    logic [PW-1:0]       amask_reg,  amask_next;
    status_t             stat_reg,   stat_next;
    logic [ADDR_W-1:0]   addr_reg,   addr_next;
    logic [WBL:0]        delta_reg,  delta_next;
    logic                dsub_reg,   dsub_next;
    logic                dvld_reg,   dvld_next;
    logic [CW-1:0]       managed_reg, managed_next;
    logic [CW-1:0]       used_reg,   used_next;
    logic                rsp_valid_reg, rsp_valid_next;
    status_t             rsp_stat_reg,  rsp_stat_next;
    logic [ADDR_W-1:0]   rsp_addr_reg,  rsp_addr_next;
    logic [USED_W-1:0]   rsp_used_reg,  rsp_used_next;

    // Map memory.
    logic [WB-1:0]       mem [WORDS];
    logic [WB-1:0]       rdata_reg;
    logic                mem_we;
    logic                mem_re;
    logic [WB-1:0]       mem_wd;

    // Per-word masks and scan results.
    logic [WB-1:0]       rmask;
    logic [WB-1:0]       almask;
    logic [WB-1:0]       fw;
    logic [WB-1:0]       m_cand;
    logic [WB-1:0]       u_used;
    logic [WBL:0]        t_used;
    logic [WBL:0]        q_idx;
    logic [WBL:0]        e_idx;
    logic [WBL:0]        run_len;
    logic [PB-1:0]       cand_sel;
    logic [PB-1:0]       re_tmp;
    logic [PB-1:0]       pg_tmp;
    logic [CW-1:0]       used_upd;
    logic [UW-1:0]       used_ext;
    logic [UW-1:0]       cfg_ext;
    logic [ADDR_W-1:0]   start_m;
    logic [ADDR_W-1:0]   end_m;
    logic [XW-1:0]       sp_x;
    logic [XW-1:0]       ep_x;
    logic [XW-1:0]       mg_x;
    logic [ALIGN_W-1:0]  ap;
    logic                word_last;

    // Ready only while idle and not being reconfigured.
    assign req.ready = (state_reg == S_IDLE) && !cfg_wr_en;

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = rsp_stat_reg;
    assign rsp.result_address = rsp_addr_reg;
    assign rsp.used_pages     = rsp_used_reg;

    // Map memory: one write port and one registered read port, both at the current word.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[w_reg] <= mem_wd;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[w_reg];
        end
    end

    // Range and alignment masks of the current word.
    always_comb
    begin
        for (int i = 0; i < WB; i++)
        begin
            rmask[i]  = (PB'({w_reg, WBL'(i)}) >= rs_reg) && (PB'({w_reg, WBL'(i)}) < re_reg);
            almask[i] = (({w_reg, WBL'(i)} & amask_reg) == '0);
        end
    end

    // Run search inside the current word.
    always_comb
    begin
        fw       = ~rdata_reg;
        t_used   = lsb_idx(rdata_reg);
        m_cand   = fw & almask & (ONES << s_reg);
        q_idx    = lsb_idx(m_cand);
        u_used   = rdata_reg & (ONES << q_idx);
        e_idx    = lsb_idx(u_used);
        run_len  = e_idx - q_idx;
        word_last = (w_reg == wlast_reg);
    end

    // Pending count update from the last modified word.
    always_comb
    begin
        if (dvld_reg)
        begin
            used_upd = dsub_reg ? used_reg - CW'(delta_reg) : used_reg + CW'(delta_reg);
        end
        else
        begin
            used_upd = used_reg;
        end
        used_ext = UW'(used_upd);
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        w_next         = w_reg;
        wlast_next     = wlast_reg;
        s_next         = s_reg;
        pend_next      = pend_reg;
        need_next      = need_reg;
        cand_next      = cand_reg;
        rs_next        = rs_reg;
        re_next        = re_reg;
        setm_next      = setm_reg;
        strict_next    = strict_reg;
        op_next        = op_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        count_next     = count_reg;
        align_next     = align_reg;
        amask_next     = amask_reg;
        stat_next      = stat_reg;
        addr_next      = addr_reg;
        delta_next     = delta_reg;
        dsub_next      = dsub_reg;
        dvld_next      = 1'b0;
        managed_next   = managed_reg;
        used_next      = used_upd;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_stat_next  = rsp_stat_reg;
        rsp_addr_next  = rsp_addr_reg;
        rsp_used_next  = rsp_used_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wd         = ONES;
        cand_sel       = pend_reg ? cand_reg : PB'({w_reg, q_idx[WBL-1:0]});
        re_tmp         = cand_sel + PB'(count_reg);
        pg_tmp         = re_tmp - PB'(1);
        start_m        = start_reg & ADDR_MASK;
        end_m          = end_reg & ADDR_MASK;
        mg_x           = XW'(managed_reg);
        sp_x           = XW'(start_m >> PAGE_SHIFT);
        ep_x           = XW'(end_m >> PAGE_SHIFT);
        ap             = align_reg - ALIGN_W'(PAGE_SHIFT);
        cfg_ext        = UW'(cfg_wr_data);

        case (state_reg)
            // Write all-ones into every map word.
            S_FILL:
            begin
                mem_we = 1'b1;
                mem_wd = ONES;
                if (w_reg == WI_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    w_next = w_reg + WI_W'(1);
                end
            end

            // Capture an accepted request.
            S_IDLE:
            begin
                if (req.valid && !cfg_wr_en)
                begin
                    op_next     = req.opcode;
                    start_next  = req.start_address;
                    end_next    = req.end_address;
                    count_next  = req.page_count;
                    align_next  = req.align_log2;
                    strict_next = req.strict;
                    addr_next   = '0;
                    stat_next   = ST_OK;
                    state_next  = S_DEC;
                end
            end

            // Check arguments and set up the word loop.
            S_DEC:
            begin
                case (op_reg)
                    OP_ALLOC:
                    begin
                        if (count_reg == '0 || align_reg < ALIGN_W'(PAGE_SHIFT))
                        begin
                            stat_next  = ST_INVALID;
                            state_next = S_DONE;
                        end
                        else if (KW'(count_reg) > KW'(managed_reg))
                        begin
                            stat_next  = ST_NO_SPACE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            pg_tmp     = PB'(managed_reg) - PB'(1);
                            amask_next = ~({PW{1'b1}} << ap);
                            w_next     = '0;
                            wlast_next = pg_tmp[WBL +: WI_W];
                            s_next     = '0;
                            pend_next  = 1'b0;
                            state_next = S_ARD;
                        end
                    end
                    OP_CLAIM:
                    begin
                        ep_x = ep_x + XW'(end_m[PAGE_SHIFT-1:0] != '0);
                        if (ep_x > mg_x)
                        begin
                            ep_x = mg_x;
                        end
                        if (sp_x >= ep_x)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            rs_next    = PB'(sp_x);
                            re_next    = PB'(ep_x);
                            pg_tmp     = PB'(ep_x) - PB'(1);
                            w_next     = sp_x[WBL +: WI_W];
                            wlast_next = pg_tmp[WBL +: WI_W];
                            setm_next  = 1'b1;
                            state_next = S_MRD;
                        end
                    end
                    OP_RELEASE:
                    begin
                        sp_x = sp_x + XW'(start_m[PAGE_SHIFT-1:0] != '0);
                        if (sp_x >= ep_x)
                        begin
                            stat_next  = strict_reg ? ST_INVALID : ST_OK;
                            state_next = S_DONE;
                        end
                        else if (sp_x >= mg_x)
                        begin
                            stat_next  = strict_reg ? ST_OUT_OF_RANGE : ST_OK;
                            state_next = S_DONE;
                        end
                        else if (ep_x > mg_x && strict_reg)
                        begin
                            stat_next  = ST_OUT_OF_RANGE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            if (ep_x > mg_x)
                            begin
                                ep_x = mg_x;
                            end
                            rs_next    = PB'(sp_x);
                            re_next    = PB'(ep_x);
                            pg_tmp     = PB'(ep_x) - PB'(1);
                            w_next     = sp_x[WBL +: WI_W];
                            wlast_next = pg_tmp[WBL +: WI_W];
                            setm_next  = 1'b0;
                            state_next = strict_reg ? S_CRD : S_MRD;
                        end
                    end
                    default:
                    begin
                        stat_next  = ST_INVALID;
                        state_next = S_DONE;
                    end
                endcase
            end

            S_ARD:
            begin
                mem_re     = 1'b1;
                state_next = S_ASCAN;
            end

            // One step of the first-fit search on the fetched word.
            S_ASCAN:
            begin
                if (pend_reg)
                begin
                    if (need_reg <= CNT_W'(t_used))
                    begin
                        state_next = S_MRD;
                    end
                    else if (t_used == (WBL+1)'(WB))
                    begin
                        need_next = need_reg - CNT_W'(WB);
                        if (word_last)
                        begin
                            stat_next  = ST_NO_SPACE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            w_next     = w_reg + WI_W'(1);
                            s_next     = '0;
                            state_next = S_ARD;
                        end
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        s_next    = t_used;
                    end
                end
                else if (m_cand == '0)
                begin
                    if (word_last)
                    begin
                        stat_next  = ST_NO_SPACE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        w_next     = w_reg + WI_W'(1);
                        s_next     = '0;
                        state_next = S_ARD;
                    end
                end
                else if (CNT_W'(run_len) >= count_reg)
                begin
                    state_next = S_MRD;
                end
                else if (e_idx == (WBL+1)'(WB))
                begin
                    pend_next = 1'b1;
                    cand_next = cand_sel;
                    need_next = count_reg - CNT_W'(run_len);
                    if (word_last)
                    begin
                        stat_next  = ST_NO_SPACE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        w_next     = w_reg + WI_W'(1);
                        s_next     = '0;
                        state_next = S_ARD;
                    end
                end
                else
                begin
                    s_next = e_idx;
                end

                // A run was found: mark it used.
                if (state_next == S_MRD)
                begin
                    rs_next    = cand_sel;
                    re_next    = re_tmp;
                    w_next     = cand_sel[WBL +: WI_W];
                    wlast_next = pg_tmp[WBL +: WI_W];
                    setm_next  = 1'b1;
                    addr_next  = ADDR_W'({cand_sel, {PAGE_SHIFT{1'b0}}});
                end
            end

            S_CRD:
            begin
                mem_re     = 1'b1;
                state_next = S_CCHK;
            end

            // Strict release: every page of the range must be used.
            S_CCHK:
            begin
                if ((rmask & fw) != '0)
                begin
                    stat_next  = ST_DOUBLE_FREE;
                    state_next = S_DONE;
                end
                else if (word_last)
                begin
                    w_next     = rs_reg[WBL +: WI_W];
                    state_next = S_MRD;
                end
                else
                begin
                    w_next     = w_reg + WI_W'(1);
                    state_next = S_CRD;
                end
            end

            S_MRD:
            begin
                mem_re     = 1'b1;
                state_next = S_MWR;
            end

            // Set or clear the range bits of one word and count the changes.
            S_MWR:
            begin
                mem_we     = 1'b1;
                dvld_next  = 1'b1;
                dsub_next  = !setm_reg;
                if (setm_reg)
                begin
                    mem_wd     = rdata_reg | rmask;
                    delta_next = popcnt(rmask & fw);
                end
                else
                begin
                    mem_wd     = rdata_reg & ~rmask;
                    delta_next = popcnt(rmask & rdata_reg);
                end
                if (word_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    w_next     = w_reg + WI_W'(1);
                    state_next = S_MRD;
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_stat_next  = stat_reg;
                    rsp_addr_next  = (stat_reg == ST_OK) ? addr_reg : '0;
                    rsp_used_next  = used_ext[USED_W-1:0];
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                w_next     = '0;
                state_next = S_FILL;
            end
        endcase

        // A managed_pages write marks everything used and restarts the fill.
        if (cfg_wr_en)
        begin
            managed_next = CW'((cfg_ext > UW'(NUM_PAGES)) ? UW'(NUM_PAGES) : cfg_ext);
            used_next    = managed_next;
            dvld_next    = 1'b0;
            w_next       = '0;
            state_next   = S_FILL;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            w_reg         <= '0;
            dvld_reg      <= 1'b0;
            managed_reg   <= CW'(NUM_PAGES);
            used_reg      <= CW'(NUM_PAGES);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            w_reg         <= w_next;
            dvld_reg      <= dvld_next;
            managed_reg   <= managed_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        wlast_reg    <= wlast_next;
        s_reg        <= s_next;
        pend_reg     <= pend_next;
        need_reg     <= need_next;
        cand_reg     <= cand_next;
        rs_reg       <= rs_next;
        re_reg       <= re_next;
        setm_reg     <= setm_next;
        strict_reg   <= strict_next;
        op_reg       <= op_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        count_reg    <= count_next;
        align_reg    <= align_next;
        amask_reg    <= amask_next;
        stat_reg     <= stat_next;
        addr_reg     <= addr_next;
        delta_reg    <= delta_next;
        dsub_reg     <= dsub_next;
        rsp_stat_reg <= rsp_stat_next;
        rsp_addr_reg <= rsp_addr_next;
        rsp_used_reg <= rsp_used_next;
    end

    // The used count never exceeds the managed page count.
    a_used_le_managed: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= managed_reg)
        else $error("used page count above managed pages");

    // An accepted request drops ready in the next cycle.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("ready stayed high after a request");

    // No request is taken while the map is being filled.
    a_no_req_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FILL |-> !req.ready)
        else $error("ready during map fill");

    // A failed or non-allocating response carries a zero address.
    a_addr_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_stat_reg != ST_OK |-> rsp_addr_reg == '0)
        else $error("nonzero address on failed request");

endmodule

// File: test/tb.sv
// Self-checking testbench for page_bitmap_allocator_core with a page-map predictor.
module tb;
    import pba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  PAGES       = 65536;
    localparam int  PG_SHIFT    = 12;
    localparam int  LIMIT       = 20000000;
    localparam int  TAIL_CYCLES = 64;
    // Opcode value that the block does not define.
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [ADDR_W-1:0]  sa;
        logic [ADDR_W-1:0]  ea;
        logic [CNT_W-1:0]   cnt;
        logic [ALIGN_W-1:0] al;
        logic               strict;
    } page_req_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] addr;
        logic [USED_W-1:0] used;
    } page_rsp_t;

    // Predicts every response from its own copy of the page map.
    class alloc_scoreboard;
        bit            used_map[PAGES];
        int            used_count;
        int            managed;
        page_rsp_t     expected_q[$];
        int            errors;
        int            op_seen[4];
        int            status_seen[8];

        function void configure(int value);
            managed = (value > PAGES) ? PAGES : value;
            foreach (used_map[i]) used_map[i] = 1'b1;
            used_count = managed;
        endfunction

        function bit is_used(longint unsigned page);
            if (page >= longint'(managed)) return 1'b1;
            return used_map[page];
        endfunction

        function void mark(longint unsigned page, bit val);
            if (page >= longint'(managed)) return;
            if (used_map[page] == val) return;
            used_map[page] = val;
            if (val) used_count++;
            else used_count--;
        endfunction

        function void note_request(page_req_t r);
            page_rsp_t       e;
            longint unsigned sp, ep, p, amask, cand, run;
            int              ap;
            bit              found;
            e.status = ST_OK;
            e.addr   = '0;
            cand     = 0;
            run      = 0;
            found    = 1'b0;
            op_seen[r.op]++;
            case (r.op)
                OP_ALLOC:
                begin
                    if (r.cnt == 0 || r.al < PG_SHIFT) e.status = ST_INVALID;
                    else if (r.cnt > managed) e.status = ST_NO_SPACE;
                    else
                    begin
                        ap = r.al - PG_SHIFT;
                        amask = (ap >= 63) ? '1 : ((64'd1 << ap) - 1);
                        for (p = 0; p < managed && !found; p++)
                        begin
                            if (is_used(p)) run = 0;
                            else if (run != 0 || (p & amask) == 0)
                            begin
                                if (run == 0) cand = p;
                                run++;
                                if (run == r.cnt) found = 1'b1;
                            end
                        end
                        if (found)
                        begin
                            for (p = cand; p < cand + r.cnt; p++) mark(p, 1'b1);
                            e.addr = ADDR_W'(cand << PG_SHIFT);
                        end
                        else e.status = ST_NO_SPACE;
                    end
                end
                OP_CLAIM:
                begin
                    sp = r.sa >> PG_SHIFT;
                    ep = (r.ea >> PG_SHIFT) + (r.ea[PG_SHIFT-1:0] != 0);
                    if (ep > managed) ep = managed;
                    for (p = sp; p < ep; p++) mark(p, 1'b1);
                end
                OP_RELEASE:
                begin
                    sp = (r.sa >> PG_SHIFT) + (r.sa[PG_SHIFT-1:0] != 0);
                    ep = r.ea >> PG_SHIFT;
                    if (sp >= ep) e.status = r.strict ? ST_INVALID : ST_OK;
                    else if (sp >= managed) e.status = r.strict ? ST_OUT_OF_RANGE : ST_OK;
                    else if (ep > managed && r.strict) e.status = ST_OUT_OF_RANGE;
                    else
                    begin
                        if (ep > managed) ep = managed;
                        if (r.strict)
                            for (p = sp; p < ep; p++)
                                if (!is_used(p)) e.status = ST_DOUBLE_FREE;
                        if (e.status == ST_OK)
                            for (p = sp; p < ep; p++) mark(p, 1'b0);
                    end
                end
                default: e.status = ST_INVALID;
            endcase
            if (e.status != ST_OK) e.addr = '0;
            e.used = USED_W'(used_count);
            status_seen[e.status]++;
            expected_q.push_back(e);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_response(page_rsp_t got);
            page_rsp_t e;
            if (expected_q.size() == 0)
            begin
                report("response with no request outstanding");
                return;
            end
            e = expected_q.pop_front();
            if (got.status !== e.status)
                report($sformatf("status %0d, expected %0d", got.status, e.status));
            if (got.addr !== e.addr)
                report($sformatf("result_address %h, expected %h", got.addr, e.addr));
            if (got.used !== e.used)
                report($sformatf("used_pages %0d, expected %0d", got.used, e.used));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    pba_req_if req_ch();
    pba_rsp_if rsp_ch();

    page_bitmap_allocator_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    alloc_scoreboard sb;
    bit              burst_mode;
    int              hold_request;
    int              cycle_count;
    int              managed_now;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("page_bitmap_allocator_core verification failed");
                $finish;
            end
        end
    end

    // Response side: checks each response and stalls at random.
    initial
    begin : response_side
        int        wait_left;
        page_rsp_t got;
        wait_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status = rsp_ch.status;
                got.addr   = rsp_ch.result_address;
                got.used   = rsp_ch.used_pages;
                sb.check_response(got);
                wait_left = burst_mode ? 0 : $urandom_range(0, 11);
            end
            if (hold_request > 0)
            begin
                wait_left = hold_request;
                hold_request = 0;
            end
            if (wait_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                wait_left--;
            end
            else rsp_ch.ready <= 1'b1;
        end
    end

    // Offers one request after a random gap and waits for it to be taken.
    task automatic send_request(page_req_t r);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.opcode        <= r.op;
        req_ch.start_address <= r.sa;
        req_ch.end_address   <= r.ea;
        req_ch.page_count    <= r.cnt;
        req_ch.align_log2    <= r.al;
        req_ch.strict        <= r.strict;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(r);
    endtask

    task automatic send_fields(logic [OP_W-1:0] op, logic [ADDR_W-1:0] sa,
                               logic [ADDR_W-1:0] ea, logic [CNT_W-1:0] cnt,
                               logic [ALIGN_W-1:0] al, logic strict);
        page_req_t r;
        r = '{op, sa, ea, cnt, al, strict};
        send_request(r);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Register write only while idle; the block refills its map afterwards.
    task automatic write_managed(int value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.configure(value);
        managed_now = sb.managed;
    endtask

    // Byte address near the managed span, with occasional wild values.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] a;
        if ($urandom_range(0, 19) == 0) a = ADDR_W'({$urandom, $urandom});
        else
        begin
            a = ADDR_W'(longint'($urandom_range(0, managed_now + 2)) << PG_SHIFT);
            if ($urandom_range(0, 3) == 0) a += ADDR_W'($urandom_range(0, 4095));
        end
        return a;
    endfunction

    task automatic random_request();
        page_req_t r;
        int        k;
        k = $urandom_range(0, 99);
        r.sa     = pick_address();
        r.ea     = ADDR_W'(r.sa + (longint'($urandom_range(0, 24)) << PG_SHIFT)
                   + ($urandom_range(0, 1) ? $urandom_range(0, 4095) : 0));
        if ($urandom_range(0, 15) == 0) r.ea = pick_address();
        r.cnt    = CNT_W'($urandom_range(1, 12));
        r.al     = ALIGN_W'($urandom_range(12, 16));
        r.strict = 1'($urandom_range(0, 1));
        if (k < 38)
        begin
            r.op = OP_ALLOC;
            if ($urandom_range(0, 19) == 0) r.cnt = CNT_W'($urandom);
            if ($urandom_range(0, 19) == 0) r.cnt = '0;
            if ($urandom_range(0, 9) == 0) r.al = ALIGN_W'($urandom_range(0, 63));
        end
        else if (k < 60) r.op = OP_CLAIM;
        else if (k < 96) r.op = OP_RELEASE;
        else r.op = OP_UNKNOWN;
        send_request(r);
    endtask

    // One phase of random traffic, with a long response hold and a sender pause.
    task automatic random_phase(int value, int count);
        write_managed(value);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 3)
            begin
                burst_mode   = 1'b1;
                hold_request = 400;
            end
            if (i == count / 3 + 12) burst_mode = 1'b0;
            if (i == (2 * count) / 3)
            begin
                req_ch.valid <= 1'b0;
                while (sb.pending() != 0) @(posedge clk);
            end
            random_request();
        end
    endtask

    // Stimulus.
    initial
    begin
        sb = new();
        sb.configure(PAGES);
        managed_now  = PAGES;
        burst_mode   = 1'b0;
        hold_request = 0;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        req_ch.valid         = 1'b0;
        req_ch.opcode        = OP_ALLOC;
        req_ch.start_address = '0;
        req_ch.end_address   = '0;
        req_ch.page_count    = '0;
        req_ch.align_log2    = '0;
        req_ch.strict        = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed cases on the full map after reset.
        send_fields(OP_ALLOC, 0, 0, 1, 12, 0);                    // everything used
        send_fields(OP_RELEASE, 0, 40'h40000, 0, 0, 1);           // free 64 pages
        send_fields(OP_RELEASE, 0, 40'h40000, 0, 0, 1);           // double free
        send_fields(OP_ALLOC, 0, 0, 1, 12, 0);
        send_fields(OP_ALLOC, 0, 0, 0, 12, 0);                    // zero pages
        send_fields(OP_ALLOC, 0, 0, 1, 11, 0);                    // alignment too fine
        send_fields(OP_ALLOC, 0, 0, 2, 63, 0);                    // only page 0 aligned
        send_fields(OP_ALLOC, 0, 0, 20'hFFFFF, 12, 0);            // more than managed
        send_fields(OP_ALLOC, 0, 0, 8, 15, 0);
        send_fields(OP_CLAIM, 40'h5000, 40'h1000, 0, 0, 0);       // reversed range
        send_fields(OP_CLAIM, 40'hFFFF_FFFF_FF, 40'hFFFF_FFFF_FF, 0, 0, 0);
        send_fields(OP_CLAIM, 40'h1800, 40'h2001, 0, 0, 0);       // rounds outward
        send_fields(OP_RELEASE, 40'h1001, 40'h1FFF, 0, 0, 1);     // empty after rounding
        send_fields(OP_RELEASE, 40'h1001, 40'h1FFF, 0, 0, 0);
        send_fields(OP_RELEASE, 40'h1_0000_0000, 40'h2_0000_0000, 0, 0, 1); // past end
        send_fields(OP_RELEASE, 40'h1_0000_0000, 40'h2_0000_0000, 0, 0, 0);
        send_fields(OP_RELEASE, 40'hFF0_0000, 40'h1001_0000, 0, 0, 1);      // runs past end
        send_fields(OP_RELEASE, 40'hFF0_0000, 40'hFF_FFFF_FFFF, 0, 0, 0);   // clipped
        send_fields(OP_UNKNOWN, '1, '1, '1, '1, 1);
        send_fields(OP_CLAIM, 0, 40'hFF_FFFF_FFFF, 0, 0, 0);      // claim everything
        send_fields(OP_ALLOC, '1, '1, 20'hFFFFF, 6'h3F, 1);

        // Random phases over several map sizes, the extremes among them.
        random_phase(256, 170);
        random_phase(0, 20);
        random_phase(1, 20);
        random_phase(131071, 40);
        random_phase(100, 150);
        random_phase(200, 160);
        drain();

        $display("Covered %0d allocate, %0d claim, %0d release, %0d unknown requests",
                 sb.op_seen[OP_ALLOC], sb.op_seen[OP_CLAIM], sb.op_seen[OP_RELEASE],
                 sb.op_seen[OP_UNKNOWN]);
        $display("over map sizes 65536, 256, 0, 1, saturated, 100 and 200; %0d mismatches",
                 sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("page_bitmap_allocator_core verification clean");
        else
            $display("page_bitmap_allocator_core verification failed");
        $finish;
    end

endmodule

// File: sim.f
src/pba_pkg.sv
src/pba_if.sv
src/page_bitmap_allocator_core.sv
test/tb.sv
